// ----- rtl/core/stmm_pkg.sv -----
// Package for the six-thruster mode mixer: mode codes, register indexes,
// field widths and the per-item flags that select the correction terms.
// No dependencies.
`default_nettype none

package stmm_pkg;

  // Field widths fixed by the register map and the item formats.
  localparam int PULSE_W  = 12;
  localparam int GAIN_W   = 10;
  localparam int OFFSET_W = 11;
  localparam int AXIS_W   = 16;
  localparam int CORR_W   = 12;
  localparam int TARGET_W = 19;
  localparam int CFG_IDX_W = 3;

  // Horizontal duties reach three full-scale axes, vertical two, so 18 bits.
  localparam int DUTY_W = 18;
  localparam int PROD_W = DUTY_W + GAIN_W + 1;
  localparam int SCALED_W = 20;
  localparam int SUM_W = 22;

  // Set point: -axis * 15 degrees, held with 14 fraction bits.
  localparam int TARGET_FRAC = 14;
  localparam int SP_MUL_W = AXIS_W + 5;
  localparam int SP_W = SP_MUL_W + TARGET_FRAC;
  localparam logic signed [TARGET_W-1:0] TARGET_LIMIT = 19'sd245760;

  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_MANUAL    = 3'd1,
    MODE_STABILIZE = 3'd2,
    MODE_ALTITUDE  = 3'd3,
    MODE_POSITION  = 3'd4,
    MODE_DOCK      = 3'd5
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_PULSE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_GAIN         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZONTAL_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_GAIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_VERTICAL_GAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DOCK_OFFSET       = 3'd7;

  // Which correction terms the mixing logic applies to an item, and whether it updates the held set points.
  typedef struct packed {
    logic add_yaw;
    logic add_depth;
    logic add_roll_pitch;
    logic add_dock;
    logic hold_update;
  } mix_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/six_thruster_mode_mixer_core.sv -----
// Six-thruster mode mixer: mode sequencing, duty scaling and pulse mixing.
// Depends on stmm_pkg for mode codes, register indexes, widths and flags.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, buttons, axes, corr_* | into core
//  output  | out_valid, out_ready, pulses, mode, sets  | out of core
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | into core
//
// Two register stages: the input register and the result register, with the
// mode update, duty multipliers, correction sums and clamps between them. An
// item accepted into the input register moves into the result register as
// soon as that register is empty or being read, and one item is accepted
// every cycle while results are taken. A stall on out_ready holds both
// registers and drops in_ready only once both are full. rst clears the modes,
// button history, set points and restores the register defaults.
`default_nettype none

module six_thruster_mode_mixer_core #(
  parameter int AXIS_FRAC_BITS = 14
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   mode_button,
  input  wire logic                                   stick_button,
  input  wire logic signed [stmm_pkg::AXIS_W-1:0]     axis_lateral,
  input  wire logic signed [stmm_pkg::AXIS_W-1:0]     axis_heave,
  input  wire logic signed [stmm_pkg::AXIS_W-1:0]     axis_turn,
  input  wire logic signed [stmm_pkg::AXIS_W-1:0]     axis_surge,
  input  wire logic signed [stmm_pkg::CORR_W-1:0]     corr_roll,
  input  wire logic signed [stmm_pkg::CORR_W-1:0]     corr_pitch,
  input  wire logic signed [stmm_pkg::CORR_W-1:0]     corr_yaw,
  input  wire logic signed [stmm_pkg::CORR_W-1:0]     corr_depth,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [stmm_pkg::PULSE_W-1:0]                port_pulse,
  output logic [stmm_pkg::PULSE_W-1:0]                starboard_pulse,
  output logic [stmm_pkg::PULSE_W-1:0]                up_a_pulse,
  output logic [stmm_pkg::PULSE_W-1:0]                up_b_pulse,
  output logic [stmm_pkg::PULSE_W-1:0]                down_a_pulse,
  output logic [stmm_pkg::PULSE_W-1:0]                down_b_pulse,
  output logic [2:0]                                  mode_now,
  output logic                                        stick_mode_now,
  output logic signed [stmm_pkg::TARGET_W-1:0]        roll_target,
  output logic signed [stmm_pkg::TARGET_W-1:0]        pitch_target,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [stmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [stmm_pkg::PULSE_W-1:0]           cfg_data
);
  import stmm_pkg::*;

  localparam int DUTY_SHIFT = AXIS_FRAC_BITS + 1;
  localparam logic signed [PROD_W:0] DUTY_BIAS = (PROD_W+1)'((1 << DUTY_SHIFT) - 1);
  localparam logic signed [SP_W-1:0] SP_BIAS = SP_W'((1 << AXIS_FRAC_BITS) - 1);

  // Configuration registers.
  logic [PULSE_W-1:0]         center_pulse, min_pulse, max_pulse;
  logic [GAIN_W-1:0]          full_gain, horizontal_gain, vertical_gain;
  logic [GAIN_W-1:0]          alt_vertical_gain;
  logic signed [OFFSET_W-1:0] dock_offset;

  // Mode state, advanced as each item moves into the result register.
  mode_t mode_reg, mode_next;
  logic  stick_mode_reg, stick_next;
  logic  mode_button_prev, stick_button_prev;

  // Input register.
  logic                     s0_valid;
  logic                     s0_mb, s0_sb;
  logic signed [AXIS_W-1:0] s0_lat, s0_heave, s0_turn, s0_surge;
  logic signed [CORR_W-1:0] s0_cr, s0_cp, s0_cy, s0_cd;

  logic out_load, s0_load;

  assign out_load = !out_valid || out_ready;
  assign s0_load  = !s0_valid || out_load;
  assign in_ready = s0_load;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- mode and duties
  logic                     mode_step;
  logic signed [DUTY_W-1:0] surge_x, turn_x, heave_x, lat_x;
  logic signed [DUTY_W-1:0] duty_stb, duty_prt, duty_v;
  logic [GAIN_W-1:0]        gain_h, gain_v;
  mix_ctrl_t                ctrl_next;

  always_comb begin
    mode_step = s0_mb && !mode_button_prev;
    mode_next = mode_reg;
    stick_next = stick_mode_reg;
    if (mode_step) begin
      unique case (mode_reg)
        MODE_NONE, MODE_DOCK: mode_next = MODE_MANUAL;
        MODE_MANUAL:          mode_next = MODE_STABILIZE;
        MODE_STABILIZE:       mode_next = MODE_ALTITUDE;
        MODE_ALTITUDE:        mode_next = MODE_POSITION;
        MODE_POSITION:        mode_next = MODE_DOCK;
        default:              mode_next = MODE_NONE;
      endcase
      stick_next = 1'b0;
    end
    // The toggle is judged on the mode after any step by the same item.
    if (s0_sb && !stick_button_prev &&
        (mode_next == MODE_POSITION || mode_next == MODE_DOCK)) begin
      stick_next = !stick_next;
    end
  end

  always_comb begin
    surge_x = DUTY_W'(s0_surge);
    turn_x  = DUTY_W'(s0_turn);
    heave_x = DUTY_W'(s0_heave);
    lat_x   = DUTY_W'(s0_lat);
    duty_stb = '0;
    duty_prt = '0;
    duty_v   = '0;
    gain_h   = '0;
    gain_v   = '0;
    ctrl_next = '0;
    unique case (mode_next)
      MODE_MANUAL: begin
        duty_stb = (surge_x <<< 1) + turn_x;
        duty_prt = (surge_x <<< 1) - turn_x;
        duty_v   = heave_x <<< 1;
        gain_h   = full_gain;
        gain_v   = full_gain;
      end
      MODE_STABILIZE: begin
        duty_stb = (surge_x <<< 1) + turn_x;
        duty_prt = (surge_x <<< 1) - turn_x;
        duty_v   = heave_x <<< 1;
        gain_h   = full_gain;
        gain_v   = vertical_gain;
        ctrl_next.add_roll_pitch = 1'b1;
      end
      MODE_ALTITUDE: begin
        duty_stb = (surge_x <<< 1) + turn_x;
        duty_prt = (surge_x <<< 1) - turn_x;
        duty_v   = heave_x <<< 1;
        gain_h   = horizontal_gain;
        gain_v   = vertical_gain;
        ctrl_next.add_roll_pitch = 1'b1;
        ctrl_next.add_depth = 1'b1;
      end
      MODE_POSITION: begin
        duty_v = heave_x <<< 1;
        gain_h = horizontal_gain;
        if (stick_next) begin
          // Alternate mapping: lateral stick drives the horizontals and the
          // turn and surge sticks become roll and pitch set points.
          duty_stb = lat_x;
          duty_prt = -lat_x;
          gain_v   = alt_vertical_gain;
          ctrl_next.hold_update = 1'b1;
        end else begin
          duty_stb = (surge_x <<< 1) + turn_x;
          duty_prt = (surge_x <<< 1) - turn_x;
          gain_v   = vertical_gain;
        end
        ctrl_next.add_roll_pitch = 1'b1;
        ctrl_next.add_depth = 1'b1;
        ctrl_next.add_yaw = 1'b1;
      end
      MODE_DOCK: begin
        ctrl_next.add_roll_pitch = 1'b1;
        ctrl_next.add_yaw = 1'b1;
        ctrl_next.add_dock = 1'b1;
      end
      default: begin
        ctrl_next = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- mixing
  function automatic logic signed [SCALED_W-1:0] scale_down(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W:0] biased;
    biased = (PROD_W+1)'(p) + ((p < 0) ? DUTY_BIAS : '0);
    return SCALED_W'(biased >>> DUTY_SHIFT);
  endfunction

  function automatic logic signed [TARGET_W-1:0] set_point(
    input logic signed [AXIS_W-1:0] axis
  );
    logic signed [SP_MUL_W-1:0] ax15;
    logic signed [SP_W-1:0]     t;
    logic signed [SP_W-1:0]     q;
    ax15 = (SP_MUL_W'(axis) <<< 4) - SP_MUL_W'(axis);
    t = -(SP_W'(ax15) <<< TARGET_FRAC);
    q = (t + ((t < 0) ? SP_BIAS : SP_W'(0))) >>> AXIS_FRAC_BITS;
    if (q > SP_W'(TARGET_LIMIT)) begin
      q = SP_W'(TARGET_LIMIT);
    end else if (q < -SP_W'(TARGET_LIMIT)) begin
      q = -SP_W'(TARGET_LIMIT);
    end
    return TARGET_W'(q);
  endfunction

  // With crossed limits the upper limit wins for values above it.
  function automatic logic [PULSE_W-1:0] clamp_pulse(
    input logic signed [SUM_W-1:0] v,
    input logic [PULSE_W-1:0]      lo,
    input logic [PULSE_W-1:0]      hi
  );
    logic signed [SUM_W-1:0] lo_x, hi_x;
    lo_x = SUM_W'($signed({1'b0, lo}));
    hi_x = SUM_W'($signed({1'b0, hi}));
    priority if (v > hi_x) return hi;
    else if (v < lo_x) return lo;
    else return PULSE_W'(v);
  endfunction

  logic signed [PROD_W-1:0] prod_stb, prod_prt, prod_v;
  logic signed [SUM_W-1:0]  c_x, yaw_x, depth_x, roll_x, pitch_x, dock_x;
  logic signed [SUM_W-1:0]  stb_sum, prt_sum, vb_sum;
  logic signed [SUM_W-1:0]  ra_sum, rb_sum, rc_sum, rd_sum;

  always_comb begin
    prod_stb = PROD_W'(duty_stb * $signed({1'b0, gain_h}));
    prod_prt = PROD_W'(duty_prt * $signed({1'b0, gain_h}));
    prod_v   = PROD_W'(duty_v * $signed({1'b0, gain_v}));
    c_x     = SUM_W'($signed({1'b0, center_pulse}));
    yaw_x   = ctrl_next.add_yaw ? SUM_W'(s0_cy) : '0;
    depth_x = ctrl_next.add_depth ? SUM_W'(s0_cd) : '0;
    roll_x  = ctrl_next.add_roll_pitch ? SUM_W'(s0_cr) : '0;
    pitch_x = ctrl_next.add_roll_pitch ? SUM_W'(s0_cp) : '0;
    dock_x  = ctrl_next.add_dock ? SUM_W'(dock_offset) : '0;
    stb_sum = c_x + SUM_W'(scale_down(prod_stb)) + yaw_x;
    prt_sum = c_x + SUM_W'(scale_down(prod_prt)) - yaw_x;
    vb_sum  = c_x + SUM_W'(scale_down(prod_v)) + depth_x + dock_x;
    ra_sum  = vb_sum - roll_x + pitch_x;
    rb_sum  = vb_sum + roll_x - pitch_x;
    rc_sum  = vb_sum + roll_x + pitch_x;
    rd_sum  = vb_sum - roll_x - pitch_x;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_pulse      <= 12'd1500;
      min_pulse         <= 12'd1000;
      max_pulse         <= 12'd2000;
      full_gain         <= 10'd500;
      horizontal_gain   <= 10'd400;
      vertical_gain     <= 10'd300;
      alt_vertical_gain <= 10'd200;
      dock_offset       <= 11'sd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_PULSE:      center_pulse <= cfg_data;
        CFG_MIN_PULSE:         min_pulse <= cfg_data;
        CFG_MAX_PULSE:         max_pulse <= cfg_data;
        CFG_FULL_GAIN:         full_gain <= cfg_data[GAIN_W-1:0];
        CFG_HORIZONTAL_GAIN:   horizontal_gain <= cfg_data[GAIN_W-1:0];
        CFG_VERTICAL_GAIN:     vertical_gain <= cfg_data[GAIN_W-1:0];
        CFG_ALT_VERTICAL_GAIN: alt_vertical_gain <= cfg_data[GAIN_W-1:0];
        CFG_DOCK_OFFSET:       dock_offset <= $signed(cfg_data[OFFSET_W-1:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_load) begin
      s0_valid <= in_valid;
    end
    if (s0_load && in_valid) begin
      s0_mb    <= mode_button;
      s0_sb    <= stick_button;
      s0_lat   <= axis_lateral;
      s0_heave <= axis_heave;
      s0_turn  <= axis_turn;
      s0_surge <= axis_surge;
      s0_cr    <= corr_roll;
      s0_cp    <= corr_pitch;
      s0_cy    <= corr_yaw;
      s0_cd    <= corr_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      mode_reg          <= MODE_NONE;
      stick_mode_reg    <= 1'b0;
      mode_button_prev  <= 1'b0;
      stick_button_prev <= 1'b0;
      roll_target       <= '0;
      pitch_target      <= '0;
    end else if (out_load) begin
      out_valid <= s0_valid;
      if (s0_valid) begin
        mode_reg          <= mode_next;
        stick_mode_reg    <= stick_next;
        mode_button_prev  <= s0_mb;
        stick_button_prev <= s0_sb;
        if (ctrl_next.hold_update) begin
          roll_target  <= set_point(s0_turn);
          pitch_target <= set_point(s0_surge);
        end
      end
    end
    if (out_load && s0_valid) begin
      port_pulse      <= clamp_pulse(prt_sum, min_pulse, max_pulse);
      starboard_pulse <= clamp_pulse(stb_sum, min_pulse, max_pulse);
      up_a_pulse      <= clamp_pulse(ra_sum, min_pulse, max_pulse);
      up_b_pulse      <= clamp_pulse(rb_sum, min_pulse, max_pulse);
      down_a_pulse    <= clamp_pulse(rc_sum, min_pulse, max_pulse);
      down_b_pulse    <= clamp_pulse(rd_sum, min_pulse, max_pulse);
      mode_now        <= mode_next;
      stick_mode_now  <= stick_next;
    end
  end

`ifndef SYNTHESIS
  // The input side may only be held off when both stages are full and stalled.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s0_valid && out_valid && !out_ready))
    else $error("in_ready low while the pipeline has room");

  // The alternate stick mapping only exists in position or dock mode.
  a_stick_mode_legal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stick_mode_now) |->
      (mode_now == MODE_POSITION || mode_now == MODE_DOCK))
    else $error("alternate stick mode outside position or dock");

  // Every pulse leaves the clamp at or below max, or pinned to min; checked on the port pulse.
  a_port_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (port_pulse <= max_pulse || port_pulse == min_pulse))
    else $error("port pulse escaped the clamp");

  // Held set points stay inside the saturation window; checked on the roll set point.
  a_roll_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_target <= TARGET_LIMIT && roll_target >= -TARGET_LIMIT))
    else $error("roll set point beyond its limit");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_six_thruster_mode_mixer_core.sv -----
// Self-checking bench for six_thruster_mode_mixer_core: a directed table walk, then
// random phases under several register settings and handshake idling patterns.
// Depends on stmm_pkg and the core; results are checked against typed rows or a mixer model.
`default_nettype none

module tb_six_thruster_mode_mixer_core;
  import stmm_pkg::*;

  localparam int AXIS_FRAC    = 14;
  localparam int N_DIRECTED   = 22;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 240;
  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 2000;
  localparam int SP_LIMIT     = 245760;

  typedef enum {
    SET_HIGH, SET_LOW, SET_CROSSED, SET_TYPICAL, SET_RANDOM
  } setting_kind_t;

  typedef struct packed {
    logic                     mb;
    logic                     sb;
    logic signed [AXIS_W-1:0] lat, heave, turn, surge;
    logic signed [CORR_W-1:0] cr, cp, cy, cd;
  } stick_sample_t;

  typedef struct packed {
    logic [PULSE_W-1:0]         port, stb, up_a, up_b, dn_a, dn_b;
    logic [2:0]                 mode;
    logic                       stick;
    logic signed [TARGET_W-1:0] roll, pitch;
  } thrust_frame_t;

  // One directed item: buttons, axes, corrections, then an optional typed frame.
  typedef struct packed {
    int mb, sb, lat, heave, turn, surge, cr, cp, cy, cd;
    int typed, port, stb, ua, ub, da, db, mode, stick, roll, pitch;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
      1, 1500, 1500, 1500, 1500, 1500, 1500, MODE_NONE, 0, 0, 0},
    '{0, 0, 32767, -32768, 32767, -32768, 2047, -2048, 2047, -2048,
      1, 1500, 1500, 1500, 1500, 1500, 1500, MODE_NONE, 0, 0, 0},
    '{0, 1, -32768, 32767, -32768, 32767, -2048, 2047, -2048, 2047,
      1, 1500, 1500, 1500, 1500, 1500, 1500, MODE_NONE, 0, 0, 0},
    '{1, 0, 0, -16384, 0, 16384, 0, 0, 0, 0,
      1, 2000, 2000, 1000, 1000, 1000, 1000, MODE_MANUAL, 0, 0, 0},
    '{1, 1, 100, 8000, -12000, 5000, 300, -300, 50, -50,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{1, 0, 0, 32767, -32768, 32767, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{0, 0, 0, -1, -1, 0, 0, 0, 0, 0,
      1, 1500, 1500, 1500, 1500, 1500, 1500, MODE_MANUAL, 0, 0, 0},
    '{1, 0, 0, 1000, 2000, -3000, 400, -200, 700, -900,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{0, 1, 5, -5, 5, -5, -2048, 2047, 0, 0,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{1, 0, 0, 2000, -2000, 3000, 100, 200, 300, 400,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{0, 0, -77, -16384, 16384, -16384, 2047, 2047, -2048, 2047,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{1, 1, 8192, 4000, -16384, 16384, 10, 20, 30, 40,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{1, 0, -32768, -300, -32768, 32767, -5, 5, -2048, 2047,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{1, 0, 32767, 0, 1234, -4321, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{0, 1, 0, 500, 700, 900, 11, 22, 33, 44,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{0, 0, 16384, -16384, 16384, 16384, -100, -200, -300, -400,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{1, 0, -32768, 32767, 32767, -32768, 0, 0, 0, 0,
      1, 1500, 1500, 1600, 1600, 1600, 1600, MODE_DOCK, 0, -18510, 64815},
    '{0, 1, 0, 0, 0, 0, 100, 50, 200, 999,
      1, 1300, 1700, 1550, 1650, 1750, 1450, MODE_DOCK, 1, -18510, 64815},
    '{0, 0, 0, 0, 0, 0, -2048, -2048, 2047, -2048,
      1, 1000, 2000, 1600, 1600, 1000, 2000, MODE_DOCK, 1, -18510, 64815},
    '{1, 0, 3000, -3000, 6000, -6000, 1, 2, 3, 4,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{0, 1, -1, 1, -1, 1, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0},
    '{1, 0, 1, 2, 3, 4, 5, 6, 7, 8,
      0, 0, 0, 0, 0, 0, 0, MODE_NONE, 0, 0, 0}
  };

  localparam setting_kind_t PHASE_SETTING [N_PHASES] = '{
    SET_HIGH, SET_LOW, SET_CROSSED, SET_TYPICAL,
    SET_RANDOM, SET_TYPICAL, SET_CROSSED, SET_RANDOM
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     mode_button = 1'b0;
  logic                     stick_button = 1'b0;
  logic signed [AXIS_W-1:0] axis_lateral = '0;
  logic signed [AXIS_W-1:0] axis_heave = '0;
  logic signed [AXIS_W-1:0] axis_turn = '0;
  logic signed [AXIS_W-1:0] axis_surge = '0;
  logic signed [CORR_W-1:0] corr_roll = '0;
  logic signed [CORR_W-1:0] corr_pitch = '0;
  logic signed [CORR_W-1:0] corr_yaw = '0;
  logic signed [CORR_W-1:0] corr_depth = '0;

  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic [PULSE_W-1:0]         port_pulse, starboard_pulse;
  logic [PULSE_W-1:0]         up_a_pulse, up_b_pulse, down_a_pulse, down_b_pulse;
  logic [2:0]                 mode_now;
  logic                       stick_mode_now;
  logic signed [TARGET_W-1:0] roll_target, pitch_target;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PULSE_W-1:0]   cfg_data = '0;

  // Local copy of the register file, at its reset values.
  int cfg_center = 1500, cfg_min = 1000, cfg_max = 2000;
  int gain_full = 500, gain_horiz = 400, gain_vert = 300, gain_alt = 200;
  int dock_off = 100;

  // Local copy of the mixer state.
  mode_t mix_mode = MODE_NONE;
  logic  stick_alt = 1'b0;
  logic  mb_prev = 1'b0, sb_prev = 1'b0;
  int    roll_hold = 0, pitch_hold = 0;

  thrust_frame_t frame_due_q [$];
  thrust_frame_t frame_want;

  logic lvl_mode = 1'b0, lvl_stick = 1'b0;
  int   send_idle_pct = 0, stall_pct = 0;
  int   mismatches = 0, frames_checked = 0, alt_frames = 0, settings_done = 0;
  int   stuck_cycles = 0;
  logic [5:0] modes_seen = '0;

  six_thruster_mode_mixer_core #(
    .AXIS_FRAC_BITS(AXIS_FRAC)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode_button    (mode_button),
    .stick_button   (stick_button),
    .axis_lateral   (axis_lateral),
    .axis_heave     (axis_heave),
    .axis_turn      (axis_turn),
    .axis_surge     (axis_surge),
    .corr_roll      (corr_roll),
    .corr_pitch     (corr_pitch),
    .corr_yaw       (corr_yaw),
    .corr_depth     (corr_depth),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .port_pulse     (port_pulse),
    .starboard_pulse(starboard_pulse),
    .up_a_pulse     (up_a_pulse),
    .up_b_pulse     (up_b_pulse),
    .down_a_pulse   (down_a_pulse),
    .down_b_pulse   (down_b_pulse),
    .mode_now       (mode_now),
    .stick_mode_now (stick_mode_now),
    .roll_target    (roll_target),
    .pitch_target   (pitch_target),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Duty is in units of 2^-(AXIS_FRAC+1); the division truncates toward zero.
  function automatic longint scaled_duty(longint duty, longint gain);
    return (duty * gain) / (longint'(1) << (AXIS_FRAC + 1));
  endfunction

  function automatic int hold_angle(longint axis);
    longint t;
    t = (-axis * 15 * 16384) / (longint'(1) << AXIS_FRAC);
    if (t > SP_LIMIT) t = SP_LIMIT;
    if (t < -SP_LIMIT) t = -SP_LIMIT;
    return int'(t);
  endfunction

  // With crossed limits the upper one wins for values above it, as it is tested first.
  function automatic logic [PULSE_W-1:0] clamp_pulse(longint v);
    if (v > cfg_max) v = cfg_max;
    else if (v < cfg_min) v = cfg_min;
    return v[PULSE_W-1:0];
  endfunction

  function automatic thrust_frame_t mix_predict(stick_sample_t s);
    longint c, vb, stb, prt, ra, rb, rc, rd, dstb, dprt, dv;
    longint lat, turn, surge, heave, cr, cp, cy, cd;
    thrust_frame_t f;
    lat = s.lat; turn = s.turn; surge = s.surge; heave = s.heave;
    cr = s.cr; cp = s.cp; cy = s.cy; cd = s.cd;
    c = cfg_center;
    dstb = 2 * surge + turn;
    dprt = 2 * surge - turn;
    dv = 2 * heave;

    if (s.mb && !mb_prev) begin
      if (mix_mode >= MODE_MANUAL && mix_mode <= MODE_POSITION)
        mix_mode = mode_t'(mix_mode + 3'd1);
      else if (mix_mode == MODE_NONE || mix_mode == MODE_DOCK)
        mix_mode = MODE_MANUAL;
      else
        mix_mode = MODE_NONE;
      stick_alt = 1'b0;
    end
    mb_prev = s.mb;
    if (s.sb && !sb_prev && (mix_mode == MODE_POSITION || mix_mode == MODE_DOCK))
      stick_alt = !stick_alt;
    sb_prev = s.sb;

    stb = c; prt = c; ra = c; rb = c; rc = c; rd = c;
    case (mix_mode)
      MODE_MANUAL: begin
        stb = c + scaled_duty(dstb, gain_full);
        prt = c + scaled_duty(dprt, gain_full);
        ra = c + scaled_duty(dv, gain_full);
        rb = ra; rc = ra; rd = ra;
      end
      MODE_STABILIZE, MODE_ALTITUDE, MODE_POSITION: begin
        if (mix_mode == MODE_STABILIZE) begin
          stb = c + scaled_duty(dstb, gain_full);
          prt = c + scaled_duty(dprt, gain_full);
          vb = c + scaled_duty(dv, gain_vert);
        end else if (mix_mode == MODE_ALTITUDE || !stick_alt) begin
          stb = c + scaled_duty(dstb, gain_horiz);
          prt = c + scaled_duty(dprt, gain_horiz);
          vb = c + scaled_duty(dv, gain_vert) + cd;
        end else begin
          // Alternate mapping: lateral drives the horizontals, set points follow the stick.
          stb = c + scaled_duty(lat, gain_horiz);
          prt = c + scaled_duty(-lat, gain_horiz);
          vb = c + scaled_duty(dv, gain_alt) + cd;
          roll_hold = hold_angle(turn);
          pitch_hold = hold_angle(surge);
        end
        if (mix_mode == MODE_POSITION) begin
          stb = stb + cy;
          prt = prt - cy;
        end
        ra = vb - cr + cp; rb = vb + cr - cp;
        rc = vb + cr + cp; rd = vb - cr - cp;
      end
      MODE_DOCK: begin
        stb = c + cy;
        prt = c - cy;
        vb = c + dock_off;
        ra = vb - cr + cp; rb = vb + cr - cp;
        rc = vb + cr + cp; rd = vb - cr - cp;
      end
      default: ;
    endcase

    f.port = clamp_pulse(prt);
    f.stb = clamp_pulse(stb);
    f.up_a = clamp_pulse(ra);
    f.up_b = clamp_pulse(rb);
    f.dn_a = clamp_pulse(rc);
    f.dn_b = clamp_pulse(rd);
    f.mode = mix_mode;
    f.stick = stick_alt;
    f.roll = roll_hold[TARGET_W-1:0];
    f.pitch = pitch_hold[TARGET_W-1:0];
    return f;
  endfunction

  function automatic logic [AXIS_W-1:0] draw_axis();
    int v;
    case ($urandom_range(9))
      0: v = -16384;
      1: v = 16384;
      2: v = int'($urandom);
      3: v = int'($urandom_range(128)) - 64;
      default: v = int'($urandom_range(32768)) - 16384;
    endcase
    return v[AXIS_W-1:0];
  endfunction

  function automatic logic [CORR_W-1:0] draw_corr();
    int v;
    case ($urandom_range(5))
      0: v = int'($urandom);
      1: v = $urandom_range(1) ? 2047 : -2048;
      default: v = int'($urandom_range(600)) - 300;
    endcase
    return v[CORR_W-1:0];
  endfunction

  // Button levels flip now and then, so edges step through every mode from manual to dock.
  function automatic stick_sample_t draw_sample();
    stick_sample_t s;
    if ($urandom_range(99) < 25) lvl_mode = !lvl_mode;
    if ($urandom_range(99) < 30) lvl_stick = !lvl_stick;
    s.mb = lvl_mode;
    s.sb = lvl_stick;
    s.lat = draw_axis();
    s.heave = draw_axis();
    s.turn = draw_axis();
    s.surge = draw_axis();
    s.cr = draw_corr();
    s.cp = draw_corr();
    s.cy = draw_corr();
    s.cd = draw_corr();
    return s;
  endfunction

  function automatic logic [PULSE_W-1:0] setting_value(setting_kind_t k,
                                                       logic [CFG_IDX_W-1:0] idx);
    logic [PULSE_W-1:0] v;
    v = PULSE_W'($urandom);
    case (k)
      SET_HIGH:
        case (idx)
          CFG_CENTER_PULSE: v = 12'd4095;
          CFG_MIN_PULSE:    v = 12'd0;
          CFG_MAX_PULSE:    v = 12'd4095;
          CFG_DOCK_OFFSET:  v = 12'hC00;
          default:          v = 12'hFFF;
        endcase
      SET_LOW:
        case (idx)
          CFG_CENTER_PULSE: v = 12'd0;
          CFG_MIN_PULSE:    v = 12'd0;
          CFG_MAX_PULSE:    v = 12'd4095;
          CFG_DOCK_OFFSET:  v = 12'h3FF;
          default:          v = 12'hC00;
        endcase
      SET_CROSSED:
        case (idx)
          CFG_CENTER_PULSE: v = 12'd1500;
          CFG_MIN_PULSE:    v = 12'd2000;
          CFG_MAX_PULSE:    v = 12'd1000;
          default: ;
        endcase
      SET_TYPICAL:
        case (idx)
          CFG_CENTER_PULSE: v = PULSE_W'(1400 + $urandom_range(200));
          CFG_MIN_PULSE:    v = PULSE_W'(900 + $urandom_range(200));
          CFG_MAX_PULSE:    v = PULSE_W'(1900 + $urandom_range(200));
          CFG_DOCK_OFFSET:  v = PULSE_W'(int'($urandom_range(600)) - 300);
          default:          v = PULSE_W'($urandom_range(1023));
        endcase
      default: ;
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    mismatches++;
    // Keep the log readable if the core is badly broken.
    if (mismatches <= 100)
      $display("mismatch at frame %0d, %s: got %0d, want %0d",
               frames_checked, what, got, want);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PULSE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CENTER_PULSE:      cfg_center = data;
      CFG_MIN_PULSE:         cfg_min = data;
      CFG_MAX_PULSE:         cfg_max = data;
      CFG_FULL_GAIN:         gain_full = data[GAIN_W-1:0];
      CFG_HORIZONTAL_GAIN:   gain_horiz = data[GAIN_W-1:0];
      CFG_VERTICAL_GAIN:     gain_vert = data[GAIN_W-1:0];
      CFG_ALT_VERTICAL_GAIN: gain_alt = data[GAIN_W-1:0];
      CFG_DOCK_OFFSET:       dock_off = $signed(data[OFFSET_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_setting(setting_kind_t k);
    write_reg(CFG_CENTER_PULSE, setting_value(k, CFG_CENTER_PULSE));
    write_reg(CFG_MIN_PULSE, setting_value(k, CFG_MIN_PULSE));
    write_reg(CFG_MAX_PULSE, setting_value(k, CFG_MAX_PULSE));
    write_reg(CFG_FULL_GAIN, setting_value(k, CFG_FULL_GAIN));
    write_reg(CFG_HORIZONTAL_GAIN, setting_value(k, CFG_HORIZONTAL_GAIN));
    write_reg(CFG_VERTICAL_GAIN, setting_value(k, CFG_VERTICAL_GAIN));
    write_reg(CFG_ALT_VERTICAL_GAIN, setting_value(k, CFG_ALT_VERTICAL_GAIN));
    write_reg(CFG_DOCK_OFFSET, setting_value(k, CFG_DOCK_OFFSET));
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Presents one item, waits for it to be taken and queues the frame it should give.
  task automatic send_sample(stick_sample_t s, bit use_typed, thrust_frame_t typed_frame);
    int gap;
    thrust_frame_t f;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode_button <= s.mb;
    stick_button <= s.sb;
    axis_lateral <= s.lat;
    axis_heave <= s.heave;
    axis_turn <= s.turn;
    axis_surge <= s.surge;
    corr_roll <= s.cr;
    corr_pitch <= s.cp;
    corr_yaw <= s.cy;
    corr_depth <= s.cd;
    do @(posedge clk); while (!in_ready);
    f = mix_predict(s);
    frame_due_q.push_back(use_typed ? typed_frame : f);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (frame_due_q.size() == 0) begin
        flag_mismatch("frame with nothing due", 1, 0);
      end else begin
        frame_want = frame_due_q.pop_front();
        if (port_pulse != frame_want.port)
          flag_mismatch("port_pulse", port_pulse, frame_want.port);
        if (starboard_pulse != frame_want.stb)
          flag_mismatch("starboard_pulse", starboard_pulse, frame_want.stb);
        if (up_a_pulse != frame_want.up_a)
          flag_mismatch("up_a_pulse", up_a_pulse, frame_want.up_a);
        if (up_b_pulse != frame_want.up_b)
          flag_mismatch("up_b_pulse", up_b_pulse, frame_want.up_b);
        if (down_a_pulse != frame_want.dn_a)
          flag_mismatch("down_a_pulse", down_a_pulse, frame_want.dn_a);
        if (down_b_pulse != frame_want.dn_b)
          flag_mismatch("down_b_pulse", down_b_pulse, frame_want.dn_b);
        if (mode_now != frame_want.mode)
          flag_mismatch("mode_now", mode_now, frame_want.mode);
        if (stick_mode_now != frame_want.stick)
          flag_mismatch("stick_mode_now", stick_mode_now, frame_want.stick);
        if (roll_target != frame_want.roll)
          flag_mismatch("roll_target", roll_target, frame_want.roll);
        if (pitch_target != frame_want.pitch)
          flag_mismatch("pitch_target", pitch_target, frame_want.pitch);
        frames_checked++;
        if (frame_want.stick) alt_frames++;
        if (frame_want.mode <= MODE_DOCK) modes_seen[frame_want.mode] = 1'b1;
      end
    end
  end

  // Ends the run if no channel has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    directed_row_t r;
    stick_sample_t s;
    thrust_frame_t f;
    int ph;
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      r = DIRECTED_ROWS[i];
      s.mb = r.mb[0];
      s.sb = r.sb[0];
      s.lat = r.lat[AXIS_W-1:0];
      s.heave = r.heave[AXIS_W-1:0];
      s.turn = r.turn[AXIS_W-1:0];
      s.surge = r.surge[AXIS_W-1:0];
      s.cr = r.cr[CORR_W-1:0];
      s.cp = r.cp[CORR_W-1:0];
      s.cy = r.cy[CORR_W-1:0];
      s.cd = r.cd[CORR_W-1:0];
      f.port = r.port[PULSE_W-1:0];
      f.stb = r.stb[PULSE_W-1:0];
      f.up_a = r.ua[PULSE_W-1:0];
      f.up_b = r.ub[PULSE_W-1:0];
      f.dn_a = r.da[PULSE_W-1:0];
      f.dn_b = r.db[PULSE_W-1:0];
      f.mode = r.mode[2:0];
      f.stick = r.stick[0];
      f.roll = r.roll[TARGET_W-1:0];
      f.pitch = r.pitch[TARGET_W-1:0];
      send_sample(s, r.typed != 0, f);
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      in_valid <= 1'b0;
      while (frame_due_q.size() != 0) @(posedge clk);
      // Let the pipeline settle before the registers change under it.
      repeat (DRAIN_CYCLES) @(posedge clk);
      program_setting(PHASE_SETTING[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++)
        send_sample(draw_sample(), 1'b0, f);
    end

    in_valid <= 1'b0;
    while (frame_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d frames checked over %0d register settings, %0d with the alternate stick mapping",
             frames_checked, settings_done + 1, alt_frames);
    $display("modes reached (dock down to none): %06b, mismatches: %0d", modes_seen, mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
